[rtl/i2cmsec_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master/slave event controller package
// Shared types and constants for the event controller.
// ----------------------------------------------------------------------------
package i2cmsec_pkg;

	localparam logic [2:0] OP_EVENT   = 3'd0;
	localparam logic [2:0] OP_START_W = 3'd1;
	localparam logic [2:0] OP_START_R = 3'd2;
	localparam logic [2:0] OP_MAP_RD  = 3'd3;
	localparam logic [2:0] OP_MAP_WR  = 3'd4;

	localparam logic [7:0] SC_BUS_ERR   = 8'h00;
	localparam logic [7:0] SC_START     = 8'h08;
	localparam logic [7:0] SC_RSTART    = 8'h10;
	localparam logic [7:0] SC_SLAW_ACK  = 8'h18;
	localparam logic [7:0] SC_SLAW_NACK = 8'h20;
	localparam logic [7:0] SC_DW_ACK    = 8'h28;
	localparam logic [7:0] SC_DW_NACK   = 8'h30;
	localparam logic [7:0] SC_ARB_LOST  = 8'h38;
	localparam logic [7:0] SC_SLAR_ACK  = 8'h40;
	localparam logic [7:0] SC_SLAR_NACK = 8'h48;
	localparam logic [7:0] SC_DR_ACK    = 8'h50;
	localparam logic [7:0] SC_DR_NACK   = 8'h58;
	localparam logic [7:0] SC_SW_ADDR   = 8'h60;
	localparam logic [7:0] SC_SW_ARBL   = 8'h68;
	localparam logic [7:0] SC_SW_DATA   = 8'h80;
	localparam logic [7:0] SC_SW_DNACK  = 8'h88;
	localparam logic [7:0] SC_SL_STOP   = 8'hA0;
	localparam logic [7:0] SC_SR_ADDR   = 8'hA8;
	localparam logic [7:0] SC_SR_DATA   = 8'hB8;
	localparam logic [7:0] SC_SR_DNACK  = 8'hC0;
	localparam logic [7:0] SC_SR_LAST   = 8'hC8;

	localparam logic [1:0] ACK_KEEP = 2'd0;
	localparam logic [1:0] ACK_SET  = 2'd1;
	localparam logic [1:0] ACK_CLR  = 2'd2;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_NACK    = 2'd1;
	localparam logic [1:0] RES_REFUSED = 2'd2;

	typedef enum logic [1:0] {MODE_IDLE, MODE_WRITE, MODE_READ} mode_t;
	typedef enum logic [1:0] {DIR_NONE, DIR_WRITE, DIR_READ} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_DECIDE, ST_COMMIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] bus_data;
		logic       bus_data_valid;
		logic [1:0] ack_action;
		logic       start_request;
		logic       clear_start;
		logic       stop_request;
		logic       tx_taken;
		logic [7:0] read_data;
		logic       read_valid;
		logic       busy_res;
		logic [1:0] result_code;
	} result_t;

endpackage

[rtl/i2cmsec_map_ram.sv]
// ----------------------------------------------------------------------------
// Map memory
// Synchronous byte memory with one write port and a registered read. After
// reset every entry is cleared, one per cycle, before the memory is used.
// ----------------------------------------------------------------------------
module i2cmsec_map_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata,
	output logic          clearing
);
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_q;
	logic [AW-1:0] clr_addr_q;
	logic          clr_act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_act_q  <= 1'b1;
		end else if (clr_act_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_act_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_act_q) begin
			mem[clr_addr_q] <= 8'd0;
		end else if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata    = rd_q;
	assign clearing = clr_act_q;
endmodule

[rtl/i2c_master_slave_event_controller.sv]
// ----------------------------------------------------------------------------
// I2C master/slave event controller
// Channel  Dir  Contents
// s_axis   in   op, status_code, rx_byte, target_addr, ... map_data
// m_axis   out  bus_data, bus_data_valid, ... result_code
// An item passes through the accept, map read, decide and result states. A slave stop
// after a slave write adds a commit state that copies each written map entry (up to
// MAP_SIZE - 1) from the shadow map through the single write port of the map memory.
// Reset clears all control registers; both map memories are then cleared entry by
// entry, and no item is taken while they are being cleared.
// A stalled result holds the block; the next item is taken once it leaves.
// ----------------------------------------------------------------------------
module i2c_master_slave_event_controller #(
	parameter int MAP_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], status_code[10:3], rx_byte[18:11], target_addr[26:19],
	// sub_addr[34:27], has_sub_addr[35], length[51:36], tx_byte[59:52],
	// map_index[67:60], map_data[75:68]
	input  logic [79:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// bus_data[7:0], bus_data_valid[8], ack_action[10:9], start_request[11],
	// clear_start[12], stop_request[13], tx_taken[14], read_data[22:15],
	// read_valid[23], busy_res[24], result_code[26:25]
	output logic [31:0] m_axis_tdata
);
	localparam int AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;

	function automatic logic [AW-1:0] map_mod(input logic [7:0] v);
		logic [8:0] x;
		x = {1'b0, v};
		for (int k = 7; k >= 0; k--) begin
			if (32'(x) >= (MAP_SIZE << k)) begin
				x = x - 9'(MAP_SIZE << k);
			end
		end
		return AW'(x);
	endfunction

	i2cmsec_pkg::state_t st_q, st_d;
	logic [79:0] it_q;
	i2cmsec_pkg::mode_t mode_q;
	logic [7:0]  raddr_q, rsub_q;
	logic        subp_q, lres_q, await_q;
	logic [15:0] wrem_q, rrem_q;
	i2cmsec_pkg::dir_t dir_q;
	logic [AW-1:0] ptr_q, cst_q, cp_q;
	i2cmsec_pkg::result_t res_q;

	logic [2:0]  op;
	logic [7:0]  code, rx, tx, midx8, mdata;
	logic [AW-1:0] midx, ptr_nx, cp_nx;

	logic          reg_we, sh_we;
	logic [AW-1:0] reg_wa, reg_ra, sh_wa, sh_ra;
	logic [7:0]    reg_wd, reg_rd, sh_wd, sh_rd;
	logic          reg_clr, sh_clr;

	assign op    = it_q[2:0];
	assign code  = it_q[10:3];
	assign rx    = it_q[18:11];
	assign tx    = it_q[59:52];
	assign midx8 = it_q[67:60];
	assign mdata = it_q[75:68];
	assign midx  = map_mod(midx8);
	assign ptr_nx = (32'(ptr_q) + 32'd1 >= 32'(MAP_SIZE)) ? '0 : ptr_q + AW'(1);
	assign cp_nx  = (32'(cp_q) + 32'd1 >= 32'(MAP_SIZE)) ? '0 : cp_q + AW'(1);

	i2cmsec_map_ram #(.DEPTH(MAP_SIZE), .AW(AW)) u_reg (
		.clk(clk), .arst_n(arst_n), .we(reg_we), .waddr(reg_wa), .wdata(reg_wd),
		.raddr(reg_ra), .rdata(reg_rd), .clearing(reg_clr)
	);
	i2cmsec_map_ram #(.DEPTH(MAP_SIZE), .AW(AW)) u_shadow (
		.clk(clk), .arst_n(arst_n), .we(sh_we), .waddr(sh_wa), .wdata(sh_wd),
		.raddr(sh_ra), .rdata(sh_rd), .clearing(sh_clr)
	);

	assign s_axis_tready = (st_q == i2cmsec_pkg::ST_IDLE) && !reg_clr && !sh_clr;
	assign m_axis_tvalid = (st_q == i2cmsec_pkg::ST_OUT);
	assign m_axis_tdata  = {5'd0,
		(res_q.result_code == i2cmsec_pkg::RES_REFUSED) ? i2cmsec_pkg::RES_REFUSED
			: {1'b0, lres_q},
		mode_q != i2cmsec_pkg::MODE_IDLE,
		res_q.read_valid, res_q.read_data, res_q.tx_taken, res_q.stop_request,
		res_q.clear_start, res_q.start_request, res_q.ack_action,
		res_q.bus_data_valid, res_q.bus_data};

	assign reg_ra = (op == i2cmsec_pkg::OP_MAP_RD) ? midx : ptr_q;
	assign sh_ra  = (st_q == i2cmsec_pkg::ST_COMMIT) ? cp_nx : cst_q;
	assign sh_we  = (st_q == i2cmsec_pkg::ST_DECIDE) && op == i2cmsec_pkg::OP_EVENT
		&& code == i2cmsec_pkg::SC_SW_DATA && !await_q;
	assign sh_wa  = ptr_q;
	assign sh_wd  = rx;

	always_comb begin
		reg_we = 1'b0;
		reg_wa = midx;
		reg_wd = mdata;
		if (st_q == i2cmsec_pkg::ST_DECIDE && op == i2cmsec_pkg::OP_MAP_WR) begin
			reg_we = 1'b1;
		end else if (st_q == i2cmsec_pkg::ST_COMMIT && cp_q != ptr_q) begin
			reg_we = 1'b1;
			reg_wa = cp_q;
			reg_wd = sh_rd;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			i2cmsec_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) st_d = i2cmsec_pkg::ST_READ;
			i2cmsec_pkg::ST_READ: st_d = i2cmsec_pkg::ST_DECIDE;
			i2cmsec_pkg::ST_DECIDE: begin
				if (op == i2cmsec_pkg::OP_EVENT && code == i2cmsec_pkg::SC_SL_STOP
						&& dir_q == i2cmsec_pkg::DIR_WRITE) begin
					st_d = i2cmsec_pkg::ST_COMMIT;
				end else begin
					st_d = i2cmsec_pkg::ST_OUT;
				end
			end
			i2cmsec_pkg::ST_COMMIT: if (cp_q == ptr_q) st_d = i2cmsec_pkg::ST_OUT;
			i2cmsec_pkg::ST_OUT: if (m_axis_tready) st_d = i2cmsec_pkg::ST_IDLE;
			default: st_d = i2cmsec_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= i2cmsec_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			it_q <= s_axis_tdata;
		end
	end

	// Result and state update for one item, evaluated in the decide state; the commit state steps the copy pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= i2cmsec_pkg::MODE_IDLE;
			raddr_q <= '0;
			rsub_q  <= '0;
			subp_q  <= 1'b0;
			wrem_q  <= '0;
			rrem_q  <= '0;
			lres_q  <= 1'b0;
			dir_q   <= i2cmsec_pkg::DIR_NONE;
			await_q <= 1'b0;
			ptr_q   <= '0;
			cst_q   <= '0;
			cp_q    <= '0;
			res_q   <= '0;
		end else if (st_q == i2cmsec_pkg::ST_COMMIT) begin
			if (cp_q != ptr_q) begin
				cp_q <= cp_nx;
			end else begin
				cst_q <= ptr_q;
			end
		end else if (st_q == i2cmsec_pkg::ST_DECIDE) begin
			i2cmsec_pkg::result_t r;
			r = '0;
			cp_q <= cst_q;
			case (op)
				i2cmsec_pkg::OP_EVENT: begin
					case (code)
						i2cmsec_pkg::SC_BUS_ERR: begin
							r.stop_request = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_START, i2cmsec_pkg::SC_RSTART: begin
							r.bus_data = raddr_q | {7'd0, mode_q == i2cmsec_pkg::MODE_READ};
							r.bus_data_valid = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
							r.clear_start = 1'b1;
						end
						i2cmsec_pkg::SC_SLAW_ACK: begin
							if (subp_q) begin
								r.bus_data = rsub_q;
								subp_q <= 1'b0;
							end else if (wrem_q != 16'd0) begin
								r.bus_data = tx;
								r.tx_taken = 1'b1;
								wrem_q <= wrem_q - 16'd1;
							end
							r.bus_data_valid = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SLAW_NACK, i2cmsec_pkg::SC_SLAR_NACK: begin
							lres_q <= 1'b1;
							wrem_q <= '0;
							rrem_q <= '0;
							mode_q <= i2cmsec_pkg::MODE_IDLE;
							r.stop_request = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_DW_ACK: begin
							if (wrem_q != 16'd0) begin
								wrem_q <= wrem_q - 16'd1;
								r.bus_data = tx;
								r.bus_data_valid = 1'b1;
								r.tx_taken = 1'b1;
							end else begin
								mode_q <= i2cmsec_pkg::MODE_IDLE;
								r.stop_request = 1'b1;
							end
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_DW_NACK: begin
							mode_q <= i2cmsec_pkg::MODE_IDLE;
							r.stop_request = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_ARB_LOST: begin
							r.start_request = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SLAR_ACK: begin
							r.ack_action = (rrem_q == 16'd1) ? i2cmsec_pkg::ACK_CLR
								: i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_DR_ACK: begin
							r.read_data = rx;
							r.read_valid = 1'b1;
							if (rrem_q != 16'd0) rrem_q <= rrem_q - 16'd1;
							r.ack_action = (rrem_q <= 16'd2) ? i2cmsec_pkg::ACK_CLR
								: i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_DR_NACK: begin
							r.read_data = rx;
							r.read_valid = 1'b1;
							mode_q <= i2cmsec_pkg::MODE_IDLE;
							r.stop_request = 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SW_ADDR: begin
							dir_q <= i2cmsec_pkg::DIR_WRITE;
							cst_q <= ptr_q;
							await_q <= 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SW_ARBL: begin
							await_q <= 1'b1;
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SW_DATA: begin
							if (await_q) begin
								await_q <= 1'b0;
								ptr_q <= map_mod(rx);
								cst_q <= map_mod(rx);
							end else begin
								ptr_q <= ptr_nx;
							end
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SW_DNACK, i2cmsec_pkg::SC_SR_DNACK,
						i2cmsec_pkg::SC_SR_LAST, i2cmsec_pkg::SC_SL_STOP: begin
							r.ack_action = i2cmsec_pkg::ACK_SET;
						end
						i2cmsec_pkg::SC_SR_ADDR, i2cmsec_pkg::SC_SR_DATA: begin
							if (code == i2cmsec_pkg::SC_SR_ADDR) dir_q <= i2cmsec_pkg::DIR_READ;
							r.bus_data = reg_rd;
							r.bus_data_valid = 1'b1;
							ptr_q <= ptr_nx;
						end
						default: ;
					endcase
				end
				i2cmsec_pkg::OP_START_W, i2cmsec_pkg::OP_START_R: begin
					if (mode_q == i2cmsec_pkg::MODE_IDLE) begin
						raddr_q <= it_q[26:19];
						subp_q  <= it_q[35];
						if (it_q[35]) rsub_q <= it_q[34:27];
						lres_q  <= 1'b0;
						if (op == i2cmsec_pkg::OP_START_W) begin
							wrem_q <= it_q[51:36];
							mode_q <= i2cmsec_pkg::MODE_WRITE;
						end else begin
							rrem_q <= it_q[51:36];
							mode_q <= i2cmsec_pkg::MODE_READ;
						end
						r.start_request = 1'b1;
					end else begin
						r.result_code = i2cmsec_pkg::RES_REFUSED;
					end
				end
				i2cmsec_pkg::OP_MAP_RD: begin
					r.read_data = reg_rd;
					r.read_valid = 1'b1;
				end
				default: ;
			endcase
			res_q <= r;
		end else if (st_q == i2cmsec_pkg::ST_OUT && m_axis_tready == 1'b0) begin
			res_q <= res_q;
		end
	end
endmodule

[test/i2c_master_slave_event_controller_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master/slave event controller testbench
// Sends a short table of directed transfers and then random bus sequences
// (master writes and reads, slave register map writes and reads, host map
// access, aborts and noise) under several idling patterns on both streams.
// Every result is decoded into its fields and checked against a built-in model, or a fixed result for typed entries.
// ----------------------------------------------------------------------------
module i2c_master_slave_event_controller_tb;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	i2c_master_slave_event_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Model state of the controller.
	i2cmsec_pkg::mode_t mst_mode = i2cmsec_pkg::MODE_IDLE;
	logic [7:0] peer_addr = '0;
	logic [7:0] dev_sub = '0;
	logic       sub_pend = 1'b0;
	logic [15:0] wr_left = '0;
	logic [15:0] rd_left = '0;
	logic       nack_seen = 1'b0;
	i2cmsec_pkg::dir_t sl_dir = i2cmsec_pkg::DIR_NONE;
	logic       sl_want_idx = 1'b0;
	logic [7:0] sl_ptr = '0;
	logic [7:0] sl_commit = '0;
	logic [7:0] reg_map [256] = '{default: '0};
	logic [7:0] shadow [256] = '{default: '0};

	i2cmsec_pkg::result_t expected_results [$];
	logic [79:0] table_item [$];
	bit         table_typed [$];
	i2cmsec_pkg::result_t table_result [$];

	bit         cur_typed;
	i2cmsec_pkg::result_t cur_result;
	int         sender_idle_pct;
	int         receiver_stall_pct;
	int         sent_count;
	int         mismatches = 0;
	int         cycles = 0;

	function automatic logic [79:0] mk(input int op, input int code, input int rx,
			input int ta, input int sa, input int hs, input int len, input int tx,
			input int mi, input int md);
		return {4'b0, 8'(md), 8'(mi), 8'(tx), 16'(len), 1'(hs), 8'(sa), 8'(ta), 8'(rx),
			8'(code), 3'(op)};
	endfunction

	function automatic i2cmsec_pkg::result_t from_bus(input logic [31:0] t);
		i2cmsec_pkg::result_t r;
		r.bus_data       = t[7:0];
		r.bus_data_valid = t[8];
		r.ack_action     = t[10:9];
		r.start_request  = t[11];
		r.clear_start    = t[12];
		r.stop_request   = t[13];
		r.tx_taken       = t[14];
		r.read_data      = t[22:15];
		r.read_valid     = t[23];
		r.busy_res       = t[24];
		r.result_code    = t[26:25];
		return r;
	endfunction

	function automatic i2cmsec_pkg::result_t predict_transfer(input logic [79:0] d);
		i2cmsec_pkg::result_t r;
		logic [2:0] op;
		logic [7:0] code, rx, tx, mi;
		logic [7:0] i;
		int         g;
		bit         refused;
		op = d[2:0];
		code = d[10:3];
		rx = d[18:11];
		tx = d[59:52];
		mi = d[67:60];
		refused = 1'b0;
		r = '0;
		case (op)
			i2cmsec_pkg::OP_EVENT: begin
				case (code)
					i2cmsec_pkg::SC_BUS_ERR: begin
						r.stop_request = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_START, i2cmsec_pkg::SC_RSTART: begin
						r.bus_data = peer_addr | {7'b0, mst_mode == i2cmsec_pkg::MODE_READ};
						r.bus_data_valid = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
						r.clear_start = 1'b1;
					end
					i2cmsec_pkg::SC_SLAW_ACK: begin
						if (sub_pend) begin
							r.bus_data = dev_sub;
							sub_pend = 1'b0;
						end else if (wr_left != 0) begin
							r.bus_data = tx;
							r.tx_taken = 1'b1;
							wr_left--;
						end
						r.bus_data_valid = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SLAW_NACK, i2cmsec_pkg::SC_SLAR_NACK: begin
						nack_seen = 1'b1;
						wr_left = '0;
						rd_left = '0;
						mst_mode = i2cmsec_pkg::MODE_IDLE;
						r.stop_request = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_DW_ACK: begin
						if (wr_left != 0) begin
							wr_left--;
							r.bus_data = tx;
							r.bus_data_valid = 1'b1;
							r.tx_taken = 1'b1;
						end else begin
							mst_mode = i2cmsec_pkg::MODE_IDLE;
							r.stop_request = 1'b1;
						end
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_DW_NACK: begin
						mst_mode = i2cmsec_pkg::MODE_IDLE;
						r.stop_request = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_ARB_LOST: begin
						r.start_request = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SLAR_ACK: r.ack_action = (rd_left == 1)
						? i2cmsec_pkg::ACK_CLR : i2cmsec_pkg::ACK_SET;
					i2cmsec_pkg::SC_DR_ACK: begin
						r.read_data = rx;
						r.read_valid = 1'b1;
						if (rd_left != 0)
							rd_left--;
						r.ack_action = (rd_left <= 1) ? i2cmsec_pkg::ACK_CLR
							: i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_DR_NACK: begin
						r.read_data = rx;
						r.read_valid = 1'b1;
						mst_mode = i2cmsec_pkg::MODE_IDLE;
						r.stop_request = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SW_ADDR: begin
						sl_dir = i2cmsec_pkg::DIR_WRITE;
						sl_commit = sl_ptr;
						sl_want_idx = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SW_ARBL: begin
						sl_want_idx = 1'b1;
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SW_DATA: begin
						if (sl_want_idx) begin
							sl_want_idx = 1'b0;
							sl_ptr = rx;
							sl_commit = rx;
						end else begin
							shadow[sl_ptr] = rx;
							sl_ptr++;
						end
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SW_DNACK, i2cmsec_pkg::SC_SR_DNACK,
					i2cmsec_pkg::SC_SR_LAST: r.ack_action = i2cmsec_pkg::ACK_SET;
					i2cmsec_pkg::SC_SL_STOP: begin
						if (sl_dir == i2cmsec_pkg::DIR_WRITE) begin
							i = sl_commit;
							g = 0;
							while (i != sl_ptr && g < 256) begin
								reg_map[i] = shadow[i];
								i++;
								g++;
							end
							sl_commit = sl_ptr;
						end
						r.ack_action = i2cmsec_pkg::ACK_SET;
					end
					i2cmsec_pkg::SC_SR_ADDR, i2cmsec_pkg::SC_SR_DATA: begin
						if (code == i2cmsec_pkg::SC_SR_ADDR)
							sl_dir = i2cmsec_pkg::DIR_READ;
						r.bus_data = reg_map[sl_ptr];
						r.bus_data_valid = 1'b1;
						sl_ptr++;
					end
					default: ;
				endcase
			end
			i2cmsec_pkg::OP_START_W, i2cmsec_pkg::OP_START_R: begin
				if (mst_mode != i2cmsec_pkg::MODE_IDLE) begin
					refused = 1'b1;
				end else begin
					peer_addr = d[26:19];
					sub_pend = d[35];
					if (d[35])
						dev_sub = d[34:27];
					nack_seen = 1'b0;
					if (op == i2cmsec_pkg::OP_START_W) begin
						wr_left = d[51:36];
						mst_mode = i2cmsec_pkg::MODE_WRITE;
					end else begin
						rd_left = d[51:36];
						mst_mode = i2cmsec_pkg::MODE_READ;
					end
					r.start_request = 1'b1;
				end
			end
			i2cmsec_pkg::OP_MAP_RD: begin
				r.read_data = reg_map[mi];
				r.read_valid = 1'b1;
			end
			i2cmsec_pkg::OP_MAP_WR: reg_map[mi] = d[75:68];
			default: ;
		endcase
		r.busy_res = (mst_mode != i2cmsec_pkg::MODE_IDLE);
		r.result_code = refused ? i2cmsec_pkg::RES_REFUSED
			: (nack_seen ? i2cmsec_pkg::RES_NACK : i2cmsec_pkg::RES_OK);
		return r;
	endfunction

	task automatic send(input logic [79:0] item, input bit typed,
			input i2cmsec_pkg::result_t res);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= item;
		cur_typed <= typed;
		cur_result <= res;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic ev(input int code, input int rx);
		send(mk(i2cmsec_pkg::OP_EVENT, code, rx, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom), 1'b0, '0);
	endtask

	task automatic add(input logic [79:0] item, input bit typed,
			input i2cmsec_pkg::result_t res);
		table_item.push_back(item);
		table_typed.push_back(typed);
		table_result.push_back(res);
	endtask

	task automatic random_sequence();
		int n;
		int kind;
		kind = $urandom_range(9);
		case (kind)
			0, 1: begin
				n = $urandom_range(4);
				send(mk(i2cmsec_pkg::OP_START_W, $urandom, $urandom, $urandom & 32'hFE,
					$urandom, $urandom, n, $urandom, $urandom, $urandom), 1'b0, '0);
				ev(i2cmsec_pkg::SC_START, $urandom);
				ev(i2cmsec_pkg::SC_SLAW_ACK, $urandom);
				repeat (n + 1)
					ev(i2cmsec_pkg::SC_DW_ACK, $urandom);
				if ($urandom_range(3) == 0)
					ev(i2cmsec_pkg::SC_DW_NACK, $urandom);
			end
			2, 3: begin
				n = $urandom_range(1, 5);
				send(mk(i2cmsec_pkg::OP_START_R, $urandom, $urandom, $urandom & 32'hFE,
					$urandom, $urandom, n, $urandom, $urandom, $urandom), 1'b0, '0);
				ev(i2cmsec_pkg::SC_START, $urandom);
				ev(i2cmsec_pkg::SC_SLAR_ACK, $urandom);
				repeat (n - 1)
					ev(i2cmsec_pkg::SC_DR_ACK, $urandom);
				ev(i2cmsec_pkg::SC_DR_NACK, $urandom);
			end
			4, 5: begin
				ev(i2cmsec_pkg::SC_SW_ADDR, $urandom);
				ev(i2cmsec_pkg::SC_SW_DATA, $urandom);
				repeat ($urandom_range(6))
					ev(i2cmsec_pkg::SC_SW_DATA, $urandom);
				if ($urandom_range(4) == 0)
					ev(i2cmsec_pkg::SC_SW_DNACK, $urandom);
				ev(i2cmsec_pkg::SC_SL_STOP, $urandom);
			end
			6: begin
				ev(i2cmsec_pkg::SC_SR_ADDR, $urandom);
				repeat ($urandom_range(5))
					ev(i2cmsec_pkg::SC_SR_DATA, $urandom);
				ev($urandom_range(1) ? i2cmsec_pkg::SC_SR_DNACK : i2cmsec_pkg::SC_SR_LAST,
					$urandom);
			end
			7: begin
				send(mk($urandom_range(1) ? i2cmsec_pkg::OP_MAP_RD : i2cmsec_pkg::OP_MAP_WR,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom), 1'b0, '0);
			end
			8: begin
				send({4'b0, 12'($urandom), $urandom, $urandom}, 1'b0, '0);
			end
			default: begin
				send(mk($urandom_range(1, 2), $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom), 1'b0, '0);
				case ($urandom_range(4))
					0: ev(i2cmsec_pkg::SC_SLAW_NACK, $urandom);
					1: ev(i2cmsec_pkg::SC_SLAR_NACK, $urandom);
					2: ev(i2cmsec_pkg::SC_ARB_LOST, $urandom);
					3: ev(i2cmsec_pkg::SC_BUS_ERR, $urandom);
					default: ev(i2cmsec_pkg::SC_RSTART, $urandom);
				endcase
				if ($urandom_range(1))
					ev(i2cmsec_pkg::SC_DW_NACK, $urandom);
			end
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

	always @(posedge clk) begin
		i2cmsec_pkg::result_t got;
		i2cmsec_pkg::result_t want;
		if (s_axis_tvalid && s_axis_tready) begin
			want = predict_transfer(s_axis_tdata);
			expected_results.push_back(cur_typed ? cur_result : want);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got = from_bus(m_axis_tdata);
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transfer %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur_typed = 1'b0;
		cur_result = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		sent_count = 0;

		add(mk(i2cmsec_pkg::OP_MAP_RD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
			i2cmsec_pkg::result_t'{read_valid: 1'b1, default: '0});
		add(mk(i2cmsec_pkg::OP_MAP_WR, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF), 1'b1, '0);
		add(mk(i2cmsec_pkg::OP_MAP_RD, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 0), 1'b1,
			i2cmsec_pkg::result_t'{read_data: 8'hFF, read_valid: 1'b1, default: '0});
		add(mk(3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF),
			1'b1, '0);
		add(mk(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_BUS_ERR, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, i2cmsec_pkg::result_t'{stop_request: 1'b1,
			ack_action: i2cmsec_pkg::ACK_SET, default: '0});
		add(mk(i2cmsec_pkg::OP_EVENT, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		add(mk(i2cmsec_pkg::OP_START_W, 0, 0, 8'hFE, 8'hAB, 1, 16'hFFFF, 0, 0, 0), 1'b1,
			i2cmsec_pkg::result_t'{start_request: 1'b1, busy_res: 1'b1, default: '0});
		add(mk(i2cmsec_pkg::OP_START_R, 0, 0, 8'h10, 0, 0, 1, 0, 0, 0), 1'b1,
			i2cmsec_pkg::result_t'{busy_res: 1'b1,
			result_code: i2cmsec_pkg::RES_REFUSED, default: '0});
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_START, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SLAW_ACK, 0, 0, 0, 0, 0, 8'h5A, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_DW_ACK, 0, 0, 0, 0, 0, 8'hFF, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SLAW_NACK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b1, i2cmsec_pkg::result_t'{stop_request: 1'b1,
			ack_action: i2cmsec_pkg::ACK_SET,
			result_code: i2cmsec_pkg::RES_NACK, default: '0});
		add(mk(i2cmsec_pkg::OP_START_W, 0, 0, 8'h20, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SLAW_ACK, 0, 0, 0, 0, 0, 8'hC3, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_DW_ACK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_START_R, 0, 0, 8'h00, 8'h77, 1, 0, 0, 0, 0), 1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_RSTART, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SLAR_ACK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_DR_ACK, 8'h5A, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_DR_NACK, 8'hFF, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SLAR_NACK, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SW_ADDR, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SW_DATA, 8'hFF, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SW_DATA, 8'h11, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SW_DATA, 8'h22, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SL_STOP, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SR_ADDR, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);
		add(mk(i2cmsec_pkg::OP_EVENT, i2cmsec_pkg::SC_SR_DATA, 0, 0, 0, 0, 0, 0, 0, 0),
			1'b0, '0);

		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (table_item[k])
			send(table_item[k], table_typed[k], table_result[k]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 47;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 47;
				end
				default: begin
					sender_idle_pct = 38;
					receiver_stall_pct = 38;
				end
			endcase
			while (sent_count < table_item.size() + (phase + 1) * RANDOM_ITEMS / 4)
				random_sequence();
		end
		s_axis_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
